@@ sv/priority_interrupt_controller_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the priority interrupt controller
// Short forms for clocked properties with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pic_pkg.sv @@
// ---------------------------------------------------------------------------
// pic_pkg
// Types, widths and event codes shared by the priority interrupt controller.
// ---------------------------------------------------------------------------
package pic_pkg;

  localparam int CHANNELS = 7;
  localparam int CHAN_W   = $clog2(CHANNELS + 1);
  localparam int VEC_BASE = 32;
  localparam int VEC_W    = $clog2(VEC_BASE + 2 * CHANNELS + 2);
  localparam int TYPE_W   = 3;

  localparam logic [TYPE_W-1:0] REQ_STROBE  = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] REQ_HOLD    = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] REQ_DISMISS = TYPE_W'(2);
  localparam logic [TYPE_W-1:0] REQ_RESET   = TYPE_W'(3);
  localparam logic [TYPE_W-1:0] REQ_SET_EN  = TYPE_W'(4);

  typedef logic [CHANNELS-1:0] mask_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    mask_t             request_lines;
    mask_t             enable_bits;
    logic              system_on;
    logic              overflow_slot;
  } item_t;

  typedef struct packed {
    mask_t             pending_bits;
    mask_t             held_bits;
    logic [CHAN_W-1:0] request_channel;
    logic [VEC_W-1:0]  vector_address;
  } result_t;

endpackage

@@ sv/pic_prio_enc.sv @@
// ---------------------------------------------------------------------------
// pic_prio_enc
// Priority encoder: the top bit of the mask is channel 1, the highest.
// ---------------------------------------------------------------------------
module pic_prio_enc (
  input  pic_pkg::mask_t                  cand,
  output pic_pkg::mask_t                  onehot,
  output logic [pic_pkg::CHAN_W-1:0]      chan
);

  // Scanning upwards lets the highest set bit overwrite any lower one.
  always_comb begin
    onehot = '0;
    chan   = '0;
    for (int i = 0; i < pic_pkg::CHANNELS; i++) begin
      if (cand[i]) begin
        onehot    = '0;
        onehot[i] = 1'b1;
        chan      = pic_pkg::CHAN_W'(pic_pkg::CHANNELS - i);
      end
    end
  end

endmodule

@@ sv/pic_core.sv @@
// ---------------------------------------------------------------------------
// pic_core
// Channel mask state, event update and the result of each beat.
// ---------------------------------------------------------------------------
module pic_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  pic_pkg::item_t   item_q,
  output pic_pkg::result_t result_next
);

  pic_pkg::mask_t pending_mask, pending_mask_next;
  pic_pkg::mask_t held_mask, held_mask_next;
  pic_pkg::mask_t enabled_mask, enabled_mask_next;
  logic           active_flag, active_flag_next;

  pic_pkg::mask_t              cand_now, cur_bit;
  pic_pkg::mask_t              cand_after, new_bit;
  logic [pic_pkg::CHAN_W-1:0]  cur_chan, new_chan;

  assign cand_now = active_flag ? (pending_mask & ~held_mask) : '0;

  pic_prio_enc u_enc_now (
    .cand   (cand_now),
    .onehot (cur_bit),
    .chan   (cur_chan)
  );

  always_comb begin
    pending_mask_next = pending_mask;
    held_mask_next    = held_mask;
    enabled_mask_next = enabled_mask;
    active_flag_next  = active_flag;
    case (item_q.req_type)
      pic_pkg::REQ_STROBE: begin
        pending_mask_next = pending_mask | (enabled_mask & item_q.request_lines);
      end
      pic_pkg::REQ_HOLD: begin
        held_mask_next = held_mask | cur_bit;
      end
      pic_pkg::REQ_DISMISS: begin
        // Only channels of lower priority than the current request stay held.
        if (cur_chan != '0) begin
          held_mask_next = held_mask & (cur_bit - pic_pkg::CHANNELS'(1));
        end
      end
      pic_pkg::REQ_RESET: begin
        pending_mask_next = '0;
        held_mask_next    = '0;
        enabled_mask_next = '0;
        active_flag_next  = 1'b0;
      end
      pic_pkg::REQ_SET_EN: begin
        enabled_mask_next = item_q.enable_bits;
        active_flag_next  = item_q.system_on;
      end
      default: begin
      end
    endcase
  end

  assign cand_after = active_flag_next ? (pending_mask_next & ~held_mask_next) : '0;

  pic_prio_enc u_enc_after (
    .cand   (cand_after),
    .onehot (new_bit),
    .chan   (new_chan)
  );

  always_comb begin
    result_next.pending_bits    = pending_mask_next;
    result_next.held_bits       = held_mask_next;
    result_next.request_channel = new_chan;
    result_next.vector_address  = '0;
    if (new_bit != '0) begin
      result_next.vector_address = pic_pkg::VEC_W'(pic_pkg::VEC_BASE)
                                 + (pic_pkg::VEC_W'(new_chan) << 1)
                                 + pic_pkg::VEC_W'(item_q.overflow_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_mask <= '0;
      held_mask    <= '0;
      enabled_mask <= '0;
      active_flag  <= 1'b0;
    end else if (advance) begin
      pending_mask <= pending_mask_next;
      held_mask    <= held_mask_next;
      enabled_mask <= enabled_mask_next;
      active_flag  <= active_flag_next;
    end
  end

endmodule

@@ sv/priority_interrupt_controller.sv @@
// ---------------------------------------------------------------------------
// priority_interrupt_controller
// Seven-channel priority interrupt unit with an input register and a
// result register around a single pass of mask update and priority encode.
// ---------------------------------------------------------------------------
//   Channel   Direction  Payload    Handshake
//   item      in         item_t     item_valid / item_ready
//   result    out        result_t   result_valid / result_ready
//
// One beat per clock is sustained while result is not back-pressured; an item is
// taken into the input register, and the update then runs from there into the
// result register, where its result is valid.
// While a result waits to be taken, the input register holds at most one beat.
// Synchronous reset clears all masks, the on flag and both valid flags.
// Back-pressure on result stalls the update stage, then item_ready.
// ---------------------------------------------------------------------------
`include "priority_interrupt_controller_assert.svh"

module priority_interrupt_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pic_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pic_pkg::result_t result
);

  pic_pkg::item_t   item_q;
  logic             item_q_valid;
  logic             advance;
  pic_pkg::result_t result_next;

  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  pic_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item_q      (item_q),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        item_q_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  `PIC_ASSERT_SAME(a_vec_matches_chan, result_valid,
    (result.request_channel == '0) == (result.vector_address == '0),
    "vector address and request channel disagree")

  `PIC_ASSERT_NEXT(a_advance_loads_result, advance, result_valid,
    "processed beat did not reach the result register")

  `PIC_ASSERT_NEXT(a_stalled_item_kept, item_q_valid && !advance, item_q_valid,
    "buffered beat lost while the result side stalled")

  `PIC_ASSERT_NEXT(a_reset_event_clears, advance && item_q.req_type == pic_pkg::REQ_RESET,
    result.pending_bits == '0 && result.held_bits == '0 && result.request_channel == '0,
    "reset event left masks or a request set")

endmodule
